### design/rgbp_pkg.sv
// ----------------------------------------------------------------------------
// RGB triplet parser package
// Shared status codes, character constants and default sizes.
// ----------------------------------------------------------------------------
package rgbp_pkg;

  localparam int NumSlotsDefault = 6;
  localparam int MaxDigits       = 3;
  localparam int SlotNumW        = 3;
  localparam int ColorW          = 24;
  localparam int FieldValW       = 10;
  localparam int DigitCntW       = 2;
  localparam int FieldIdxW       = 2;
  localparam logic [9:0] FieldMax = 10'd255;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFormat = 2'd1,
    StValue  = 2'd2,
    StSlot   = 2'd3
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [ColorW-1:0] color;
  } result_t;

endpackage

### design/rgbp_line_core.sv
// ----------------------------------------------------------------------------
// RGB triplet parser line core
// Per-character parse state update, line-end evaluation and slot bookkeeping.
// ----------------------------------------------------------------------------
module rgbp_line_core import rgbp_pkg::*; #(
  parameter int NumSlots = NumSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          text_char_i,
  input  logic                line_end_i,
  input  logic [SlotNumW-1:0] target_slot_i,
  output result_t             result_o
);

  localparam int SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  typedef enum logic [1:0] {
    PhLead   = 2'd0,
    PhDigits = 2'd1,
    PhTrail  = 2'd2
  } phase_e;

  logic [FieldIdxW-1:0] idx_q, idx_d;
  phase_e               phase_q, phase_d;
  logic [DigitCntW-1:0] cnt_q, cnt_d;
  logic [FieldValW-1:0] val_q, val_d;
  logic [ColorW-1:0]    packed_q, packed_d;
  status_e              err_q, err_d;
  logic [NumSlots-1:0]  filled_q, filled_d;

  logic                 is_blank, is_digit, is_comma;
  logic [3:0]           digit;
  logic [13:0]          four_val;
  logic                 in_range;
  logic [SlotW-1:0]     slot_idx;
  logic                 val_ok_trail;

  assign is_blank = (text_char_i == CharSpace) || (text_char_i == CharTab);
  assign is_digit = (text_char_i >= CharZero) && (text_char_i <= CharNine);
  assign is_comma = (text_char_i == CharComma);
  assign digit    = 4'(text_char_i - CharZero);
  assign four_val = 14'(val_q) * 14'd10 + 14'(digit);
  assign in_range = int'(target_slot_i) < NumSlots;
  assign slot_idx = SlotW'(target_slot_i);

  always_comb begin
    idx_d        = idx_q;
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    val_d        = val_q;
    packed_d     = packed_q;
    err_d        = err_q;
    filled_d     = filled_q;
    result_o     = '{status: StOk, color: '0};
    val_ok_trail = 1'b0;

    if (!line_end_i) begin
      if (err_q == StOk) begin
        case (phase_q)
          PhLead: begin
            if (is_digit) begin
              phase_d = PhDigits;
              cnt_d   = DigitCntW'(1);
              val_d   = FieldValW'(digit);
            end else if (!is_blank) begin
              err_d = StFormat;
            end
          end
          PhDigits: begin
            if (is_digit) begin
              if (int'(cnt_q) < MaxDigits) begin
                val_d = 10'(four_val);
                cnt_d = cnt_q + DigitCntW'(1);
              end else begin
                err_d = (four_val > 14'd255) ? StValue : StFormat;
              end
            end else if (val_q > FieldMax) begin
              err_d = StValue;
            end else begin
              phase_d      = PhTrail;
              val_ok_trail = 1'b1;
            end
          end
          PhTrail: val_ok_trail = 1'b1;
          default: err_d = StFormat;
        endcase

        // Character following a finished field: blank, comma or stray
        if (val_ok_trail && !is_blank) begin
          if (!is_comma || idx_q >= FieldIdxW'(2)) begin
            err_d = StFormat;
          end else begin
            if (idx_q == '0) begin
              packed_d[23:16] = val_q[7:0];
            end else begin
              packed_d[15:8] = val_q[7:0];
            end
            idx_d   = idx_q + FieldIdxW'(1);
            phase_d = PhLead;
            cnt_d   = '0;
            val_d   = '0;
          end
        end
      end
    end else begin
      // Line end: resolve status, output colour and mark the slot filled, clear line state
      if (err_q != StOk) begin
        result_o.status = err_q;
      end else if (phase_q == PhDigits && val_q > FieldMax) begin
        result_o.status = StValue;
      end else if ((phase_q != PhDigits && phase_q != PhTrail) ||
                   idx_q != FieldIdxW'(2)) begin
        result_o.status = StFormat;
      end else if (!in_range || filled_q[slot_idx]) begin
        result_o.status = StSlot;
      end else begin
        result_o.color     = {packed_q[23:8], val_q[7:0]};
        filled_d[slot_idx] = 1'b1;
      end
      idx_d    = '0;
      phase_d  = PhLead;
      cnt_d    = '0;
      val_d    = '0;
      packed_d = '0;
      err_d    = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      phase_q  <= PhLead;
      cnt_q    <= '0;
      val_q    <= '0;
      packed_q <= '0;
      err_q    <= StOk;
      filled_q <= '0;
    end else if (fire_i) begin
      idx_q    <= idx_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      val_q    <= val_d;
      packed_q <= packed_d;
      err_q    <= err_d;
      filled_q <= filled_d;
    end
  end

endmodule

### design/rgb_triplet_text_parser.sv
// A line-end transaction passes the input register and then the result register.
// Throughput: one character per cycle unless a line end is held; the parse state
// update is combinational logic between the input register and the result register. A line
// end waits in the input register while a held result occupies the output.
// Reset: asynchronous, active low; clears parse state, all slot-filled flags
// and both pipeline valid flags. No clearing pass is needed.
// ----------------------------------------------------------------------------
// RGB triplet text parser
// Parses "R,G,B" decimal colour lines one character at a time and reports a
// status and packed colour per line, tracking which colour slots are filled.
// ----------------------------------------------------------------------------
module rgb_triplet_text_parser import rgbp_pkg::*; #(
  parameter int NumSlots = NumSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          text_char_i,
  input  logic                line_end_i,
  input  logic [SlotNumW-1:0] target_slot_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [ColorW-1:0]   color_o
);

  logic                in_valid_q;
  logic [7:0]          char_q;
  logic                end_q;
  logic [SlotNumW-1:0] slot_q;
  logic                out_valid_q;
  result_t             res_q;
  result_t             res;
  logic                out_free;
  logic                fire;

  // Hold a line-end transaction until the result register can take it
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && (!end_q || out_free);
  assign in_ready_o = !in_valid_q || fire;

  rgbp_line_core #(
    .NumSlots(NumSlots)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .text_char_i  (char_q),
    .line_end_i   (end_q),
    .target_slot_i(slot_q),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= text_char_i;
      end_q  <= line_end_i;
      slot_q <= target_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && end_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fire && end_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign color_o     = res_q.color;

endmodule
